/* sv/pfra_pkg.sv */
// Package for the page frame allocator: shared widths, payload structs,
// action, status and register codes, and controller/datapath signal groups.
// No dependencies.
`timescale 1ns / 1ps

package pfra_pkg;

  localparam int PAGE_W    = 10;
  localparam int NUM_PAGES = 1 << PAGE_W;
  localparam int REG_W     = 11;
  localparam int CNT_W     = 8;
  localparam int CFG_IDX_W = 2;

  localparam logic [CNT_W-1:0] RESERVED_MARK = 8'd100;
  localparam logic [CNT_W-1:0] CNT_MAX       = 8'd255;

  // Actions.
  localparam logic [2:0] ACT_ALLOC_GEN = 3'd0;
  localparam logic [2:0] ACT_ALLOC_OBJ = 3'd1;
  localparam logic [2:0] ACT_SHARE     = 3'd2;
  localparam logic [2:0] ACT_FREE      = 3'd3;
  localparam logic [2:0] ACT_QUERY     = 3'd4;
  localparam logic [2:0] ACT_SET       = 3'd5;

  // Result status codes.
  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_KERNEL = 3'd1;
  localparam logic [2:0] ST_FREE   = 3'd2;
  localparam logic [2:0] ST_EMPTY  = 3'd3;
  localparam logic [2:0] ST_SAT    = 3'd4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_OBJ_START = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GEN_START = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GEN_END   = 2'd2;

  typedef struct packed {
    logic [2:0]        action;
    logic [PAGE_W-1:0] page_number;
    logic [CNT_W-1:0]  count_value;
  } req_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [PAGE_W-1:0] result_page;
    logic [CNT_W-1:0]  result_count;
  } rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_en;
    logic take;
    logic exec;
    logic scan_go;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;
    logic scan_done;
    logic out_free;
  } sts_t;

  // Limit a scan bound to the size of the count store.
  function automatic logic [REG_W-1:0] clip_pages(input logic [REG_W-1:0] v);
    logic [REG_W-1:0] lim;
    lim = REG_W'(NUM_PAGES);
    return (v > lim) ? lim : v;
  endfunction

endpackage

/* sv/pfra_ctrl.sv */
// Controller state machine for the page frame allocator.
// Depends on pfra_pkg for the command and status groups and action codes.
`timescale 1ns / 1ps

module pfra_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  input  logic [2:0]    req_action,
  input  pfra_pkg::sts_t sts,
  output logic          req_stall,
  output pfra_pkg::cmd_t cmd
);

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_EXEC  = 4'b0100,
    S_SCAN  = 4'b1000
  } state_t;

  state_t state, state_next;
  logic   is_alloc;

  assign is_alloc = (req_action == pfra_pkg::ACT_ALLOC_GEN) ||
                    (req_action == pfra_pkg::ACT_ALLOC_OBJ);

  assign req_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_CLEAR: begin
        cmd.clr_en = 1'b1;
        if (sts.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_valid) begin
          cmd.take   = 1'b1;
          state_next = is_alloc ? S_SCAN : S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.out_free) begin
          cmd.exec   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_SCAN: begin
        if (sts.out_free) begin
          cmd.scan_go = 1'b1;
          if (sts.scan_done) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // An accepted allocation must always enter the scan.
  a_alloc_scans: assert property (@(posedge clk) disable iff (rst)
    (cmd.take && is_alloc) |=> (state == S_SCAN))
    else $error("allocation transfer did not start a scan");

endmodule

/* sv/pfra_dp.sv */
// Datapath for the page frame allocator: count store, region registers,
// scan pointers and the result register.
// Depends on pfra_pkg; driven by commands from pfra_ctrl.
`timescale 1ns / 1ps

module pfra_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  pfra_pkg::req_t                      req,
  input  logic                                cfg_we,
  input  logic [pfra_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pfra_pkg::REG_W-1:0]          cfg_data,
  input  pfra_pkg::cmd_t                      cmd,
  input  logic                                rsp_stall,
  output pfra_pkg::sts_t                      sts,
  output logic                                rsp_valid,
  output pfra_pkg::rsp_t                      rsp
);

  logic [pfra_pkg::CNT_W-1:0]  mem [pfra_pkg::NUM_PAGES];
  logic [pfra_pkg::CNT_W-1:0]  rdata;
  logic                        re;
  logic [pfra_pkg::PAGE_W-1:0] raddr;
  logic                        we;
  logic [pfra_pkg::PAGE_W-1:0] waddr;
  logic [pfra_pkg::CNT_W-1:0]  wdata;

  logic [pfra_pkg::REG_W-1:0]  obj_start, gen_start, gen_end;
  logic [pfra_pkg::REG_W-1:0]  scan_lo, scan_hi;
  logic [pfra_pkg::REG_W-1:0]  scan_ptr, scan_end;
  logic [pfra_pkg::PAGE_W-1:0] chk_ptr;
  logic                        chk_valid;
  logic [pfra_pkg::PAGE_W-1:0] clr_ptr;
  pfra_pkg::req_t              cur;

  logic                        kern, scan_more, hit, empty, rsp_load;
  logic [2:0]                  ex_status;
  logic [pfra_pkg::CNT_W-1:0]  ex_count;
  logic                        ex_we;
  pfra_pkg::rsp_t              rsp_next;

  // Region registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      obj_start <= '0;
      gen_start <= '0;
      gen_end   <= pfra_pkg::REG_W'(pfra_pkg::NUM_PAGES);
    end else if (cfg_we) begin
      case (cfg_index)
        pfra_pkg::CFG_OBJ_START: obj_start <= cfg_data;
        pfra_pkg::CFG_GEN_START: gen_start <= cfg_data;
        pfra_pkg::CFG_GEN_END:   gen_end   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Single-page action evaluation on the count read back from the store.
  assign kern = ({1'b0, cur.page_number} < obj_start);

  always_comb begin
    ex_status = pfra_pkg::ST_OK;
    ex_count  = rdata;
    ex_we     = 1'b0;
    case (cur.action)
      pfra_pkg::ACT_SHARE: begin
        if (kern) begin
          ex_status = pfra_pkg::ST_KERNEL;
        end else if (rdata == pfra_pkg::CNT_MAX) begin
          ex_status = pfra_pkg::ST_SAT;
        end else begin
          ex_count = rdata + 8'd1;
          ex_we    = 1'b1;
        end
      end
      pfra_pkg::ACT_FREE: begin
        if (kern) begin
          ex_status = pfra_pkg::ST_KERNEL;
        end else if (rdata == '0) begin
          ex_status = pfra_pkg::ST_FREE;
        end else begin
          ex_count = rdata - 8'd1;
          ex_we    = 1'b1;
        end
      end
      pfra_pkg::ACT_SET: begin
        ex_count = cur.count_value;
        ex_we    = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Scan: one read issued and one earlier read checked every cycle while the result register is free.
  assign scan_lo   = (req.action == pfra_pkg::ACT_ALLOC_OBJ) ? obj_start : gen_start;
  assign scan_hi   = (req.action == pfra_pkg::ACT_ALLOC_OBJ) ? gen_start : gen_end;
  assign scan_more = (scan_ptr < scan_end);
  assign hit       = chk_valid && (rdata == '0);
  assign empty     = !hit && !scan_more;

  always_ff @(posedge clk) begin
    if (rst) begin
      chk_valid <= 1'b0;
    end else if (cmd.take) begin
      chk_valid <= 1'b0;
    end else if (cmd.scan_go) begin
      chk_valid <= scan_more;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      cur      <= req;
      scan_ptr <= pfra_pkg::clip_pages(scan_lo);
      scan_end <= pfra_pkg::clip_pages(scan_hi);
    end else if (cmd.scan_go && scan_more) begin
      chk_ptr  <= scan_ptr[pfra_pkg::PAGE_W-1:0];
      scan_ptr <= scan_ptr + pfra_pkg::REG_W'(1);
    end
  end

  // Clearing pass after reset.
  assign sts.clr_last = (clr_ptr == {pfra_pkg::PAGE_W{1'b1}});

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_ptr <= '0;
    end else if (cmd.clr_en) begin
      clr_ptr <= clr_ptr + pfra_pkg::PAGE_W'(1);
    end
  end

  // Count store ports.
  assign re    = cmd.take || (cmd.scan_go && scan_more);
  assign raddr = cmd.take ? req.page_number : scan_ptr[pfra_pkg::PAGE_W-1:0];

  always_comb begin
    we    = 1'b0;
    waddr = cur.page_number;
    wdata = ex_count;
    if (cmd.clr_en) begin
      we    = 1'b1;
      waddr = clr_ptr;
      wdata = pfra_pkg::RESERVED_MARK;
    end else if (cmd.exec) begin
      we = ex_we;
    end else if (cmd.scan_go && hit) begin
      we    = 1'b1;
      waddr = chk_ptr;
      wdata = 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  // Result register.
  assign sts.scan_done = hit || empty;
  assign sts.out_free  = !rsp_valid || !rsp_stall;
  assign rsp_load      = cmd.exec || (cmd.scan_go && sts.scan_done);

  always_comb begin
    if (cmd.exec) begin
      rsp_next = '{status: ex_status, result_page: cur.page_number,
                   result_count: ex_count};
    end else if (hit) begin
      rsp_next = '{status: pfra_pkg::ST_OK, result_page: chk_ptr,
                   result_count: 8'd1};
    end else begin
      rsp_next = '{status: pfra_pkg::ST_EMPTY, result_page: '0,
                   result_count: '0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp <= rsp_next;
    end
  end

  a_hit_result: assert property (@(posedge clk) disable iff (rst)
    (cmd.scan_go && hit) |=> (rsp_valid && rsp.status == pfra_pkg::ST_OK &&
                              rsp.result_count == 8'd1))
    else $error("scan hit did not produce an ok result with count one");

  a_one_finisher: assert property (@(posedge clk) disable iff (rst)
    !(cmd.exec && cmd.scan_go))
    else $error("single-page finish and scan step in the same cycle");

  a_clear_quiet: assert property (@(posedge clk) disable iff (rst)
    cmd.clr_en |-> !rsp_valid)
    else $error("result pending during the clearing pass");

endmodule

/* sv/page_frame_refcount_allocator_top.sv */
// A share, free, query or set reads its count when the input transfer is taken and loads
// the result register once the output register is free. An allocation scans from the
// scan start, one count store read per cycle while the output register is free, and ends
// on the first free page or, out of pages, at the region end. The next transfer is taken
// only once the result is loaded. After reset a clearing pass writes the reserved mark
// into every entry; no input transfer is taken until it ends (configuration writes are).
`timescale 1ns / 1ps

// The block holds one item at a time. A finished result sits in the output
// register, so the next item can be taken while the result still waits;
// that item finishes only once the output register is free again.
module page_frame_refcount_allocator_top (
  input  logic                            clk,
  input  logic                            rst,
  // Request channel.
  input  logic                            req_valid,
  output logic                            req_stall,
  input  pfra_pkg::req_t                  req,
  // Result channel.
  output logic                            rsp_valid,
  input  logic                            rsp_stall,
  output pfra_pkg::rsp_t                  rsp,
  // Configuration write port: region bounds.
  input  logic                            cfg_we,
  input  logic [pfra_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pfra_pkg::REG_W-1:0]      cfg_data
);

  pfra_pkg::cmd_t cmd;
  pfra_pkg::sts_t sts;

  // The controller sequences the clearing pass, single-page actions and
  // allocation scans; it sees only the action code of the incoming request.
  pfra_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_action (req.action),
    .sts        (sts),
    .req_stall  (req_stall),
    .cmd        (cmd)
  );

  // The datapath owns the count store, the region registers, the scan
  // pointers and the result register.
  pfra_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .rsp_stall (rsp_stall),
    .sts       (sts),
    .rsp_valid (rsp_valid),
    .rsp       (rsp)
  );

endmodule

/* verif/pfra_checker.sv */
// Scoreboard for the page frame allocator: watches the request, result and
// configuration ports, predicts each result and compares it field by field.
// Depends on pfra_pkg for the payload structs and the action and status codes.
`timescale 1ns / 1ps

module pfra_checker
  import pfra_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  input  logic                 req_stall,
  input  req_t                 req,
  input  logic                 rsp_valid,
  input  logic                 rsp_stall,
  input  rsp_t                 rsp,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]     cfg_data,
  output int unsigned          mismatches,
  output int unsigned          outstanding
);

  logic [CNT_W-1:0] share_counts [NUM_PAGES];
  logic [REG_W-1:0] obj_start_pg;
  logic [REG_W-1:0] gen_start_pg;
  logic [REG_W-1:0] gen_end_pg;
  rsp_t             pending_results [$];
  int unsigned      errors = 0;

  // First free page in [lo, hi), both bounds limited to the store size.
  function automatic rsp_t first_free_page(input int lo, input int hi);
    rsp_t res;
    logic found;
    int   pg;
    res   = '0;
    res.status = ST_EMPTY;
    found = 1'b0;
    if (lo > NUM_PAGES) lo = NUM_PAGES;
    if (hi > NUM_PAGES) hi = NUM_PAGES;
    for (pg = lo; pg < hi && !found; pg++) begin
      if (share_counts[pg] == '0) begin
        share_counts[pg]  = 8'd1;
        res.status        = ST_OK;
        res.result_page   = pg[PAGE_W-1:0];
        res.result_count  = 8'd1;
        found             = 1'b1;
      end
    end
    return res;
  endfunction

  // Applies one request to the shadow count store and returns its result.
  function automatic rsp_t apply_request(input req_t r);
    rsp_t             res;
    logic [CNT_W-1:0] cur;
    logic             kernel_page;
    cur              = share_counts[r.page_number];
    kernel_page      = {1'b0, r.page_number} < obj_start_pg;
    res.status       = ST_OK;
    res.result_page  = r.page_number;
    res.result_count = cur;
    case (r.action)
      ACT_ALLOC_GEN: res = first_free_page(int'(gen_start_pg), int'(gen_end_pg));
      ACT_ALLOC_OBJ: res = first_free_page(int'(obj_start_pg), int'(gen_start_pg));
      ACT_SHARE: begin
        if (kernel_page) begin
          res.status = ST_KERNEL;
        end else if (cur == CNT_MAX) begin
          res.status = ST_SAT;
        end else begin
          share_counts[r.page_number] = cur + 8'd1;
          res.result_count = cur + 8'd1;
        end
      end
      ACT_FREE: begin
        if (kernel_page) begin
          res.status = ST_KERNEL;
        end else if (cur == '0) begin
          res.status = ST_FREE;
        end else begin
          share_counts[r.page_number] = cur - 8'd1;
          res.result_count = cur - 8'd1;
        end
      end
      ACT_SET: begin
        share_counts[r.page_number] = r.count_value;
        res.result_count = r.count_value;
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic log_failure(input string why, input rsp_t want, input rsp_t got);
    errors++;
    if (errors <= 10) begin
      $display("%0t ns: %s: expected status %0d page %0d count %0d, %s %0d page %0d count %0d",
               $time, why, want.status, want.result_page, want.result_count,
               "got status", got.status, got.result_page, got.result_count);
    end
  endtask

  always @(posedge clk) begin : watch
    rsp_t want;
    if (rst) begin
      for (int i = 0; i < NUM_PAGES; i++) share_counts[i] = RESERVED_MARK;
      obj_start_pg = '0;
      gen_start_pg = '0;
      gen_end_pg   = REG_W'(NUM_PAGES);
      pending_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_OBJ_START: obj_start_pg = cfg_data;
          CFG_GEN_START: gen_start_pg = cfg_data;
          CFG_GEN_END:   gen_end_pg   = cfg_data;
          default: ;
        endcase
      end
      if (rsp_valid && !rsp_stall) begin
        if (pending_results.size() == 0) begin
          log_failure("result with nothing expected", '0, rsp);
        end else begin
          want = pending_results.pop_front();
          if (rsp.status !== want.status || rsp.result_page !== want.result_page ||
              rsp.result_count !== want.result_count)
            log_failure("result mismatch", want, rsp);
        end
      end
      if (req_valid && !req_stall) pending_results.push_back(apply_request(req));
    end
    mismatches  <= errors;
    outstanding <= pending_results.size();
  end

endmodule

/* verif/tb.sv */
// Top of the page frame allocator testbench: clock, reset, request and
// configuration stimulus, random stalls, watchdog and final verdict.
// Depends on pfra_pkg, page_frame_refcount_allocator_top and pfra_checker.
`timescale 1ns / 1ps

module tb;
  import pfra_pkg::*;

  // Action codes that the block does not define; it answers them as a query.
  localparam logic [2:0] ACT_SPARE_LO = 3'd6;
  localparam logic [2:0] ACT_SPARE_HI = 3'd7;

  // Cycles without any transfer before the run is declared hung. The longest
  // honest quiet stretch is the clearing pass after reset or a full scan that
  // finds no free page, plus random gaps.
  localparam int unsigned QUIET_LIMIT = 12000;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 req_valid = 1'b0;
  req_t                 req       = '0;
  logic                 rsp_stall = 1'b0;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [REG_W-1:0]     cfg_data  = '0;
  logic                 req_stall;
  logic                 rsp_valid;
  rsp_t                 rsp;

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned quiet_cycles  = 0;
  int unsigned send_idle_pct = 0;
  int unsigned rsp_stall_pct = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  page_frame_refcount_allocator_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  pfra_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .req         (req),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .rsp         (rsp),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // The result side stalls at random; the chance is set per phase. A stall
  // decision is made fresh every cycle, so gaps land on every phase of a scan.
  always @(posedge clk) begin
    rsp_stall <= (rsp_stall_pct != 0) && ($urandom_range(99) < rsp_stall_pct);
  end

  // Any transfer on either channel, or a register write, counts as progress.
  always @(posedge clk) begin
    if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("page_frame_refcount_allocator_top regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one request and returns at the edge where its transfer happens.
  // Valid is left high on return; the next call or the drain decides whether
  // it drops, so it is never lowered and raised within one time step.
  task automatic send_item(input logic [2:0] act, input logic [PAGE_W-1:0] page,
                           input logic [CNT_W-1:0] cnt);
    if ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    req_valid <= 1'b1;
    req       <= '{action: act, page_number: page, count_value: cnt};
    @(posedge clk);
    while (req_stall) @(posedge clk);
  endtask

  // Stops offering requests and waits until every predicted result has come
  // back. Each request yields exactly one result, so a few cycles of margin
  // are enough before the block can be treated as idle.
  task automatic drain();
    req_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes all three region bounds on consecutive edges.
  task automatic set_regions(input logic [REG_W-1:0] obj_start,
                             input logic [REG_W-1:0] gen_start,
                             input logic [REG_W-1:0] gen_end);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_OBJ_START;
    cfg_data  <= obj_start;
    @(posedge clk);
    cfg_index <= CFG_GEN_START;
    cfg_data  <= gen_start;
    @(posedge clk);
    cfg_index <= CFG_GEN_END;
    cfg_data  <= gen_end;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Random traffic. Most pages fall in a window around the configured regions
  // so that counts get set, shared, freed and reallocated many times over; the
  // rest spread over the whole store. Set writes zero half the time, freeing pages
  // for the allocators, else saturation, the value below it, one or any value.
  task automatic run_phase(input int unsigned items, input int unsigned win_lo,
                           input int unsigned win_hi);
    int unsigned      pick;
    logic [2:0]       act;
    logic [PAGE_W-1:0] page;
    logic [CNT_W-1:0] cnt;
    for (int unsigned n = 0; n < items; n++) begin
      pick = $urandom_range(99);
      if (pick < 14)      act = ACT_ALLOC_GEN;
      else if (pick < 28) act = ACT_ALLOC_OBJ;
      else if (pick < 44) act = ACT_SHARE;
      else if (pick < 62) act = ACT_FREE;
      else if (pick < 70) act = ACT_QUERY;
      else if (pick < 93) act = ACT_SET;
      else if (pick < 96) act = ACT_SPARE_LO;
      else                act = ACT_SPARE_HI;
      if ($urandom_range(9) < 8) page = PAGE_W'($urandom_range(win_hi - 1, win_lo));
      else                       page = PAGE_W'($urandom_range(NUM_PAGES - 1));
      pick = $urandom_range(9);
      if (pick < 5)       cnt = '0;
      else if (pick == 5) cnt = CNT_MAX;
      else if (pick == 6) cnt = CNT_MAX - 8'd1;
      else if (pick == 7) cnt = 8'd1;
      else                cnt = CNT_W'($urandom_range(255));
      send_item(act, page, cnt);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Small regions: kernel pages 0..7, object region 8..15, general 16..31.
    // Every count starts at the reserved mark, so nothing is free yet.
    set_regions(11'd8, 11'd16, 11'd32);
    send_item(ACT_QUERY, 10'd0, 8'd0);
    send_item(ACT_QUERY, 10'd1023, 8'd255);
    send_item(ACT_ALLOC_GEN, 10'd0, 8'd0);
    send_item(ACT_ALLOC_OBJ, 10'd0, 8'd0);
    // Share and free are refused on kernel pages.
    send_item(ACT_SHARE, 10'd3, 8'd0);
    send_item(ACT_FREE, 10'd7, 8'd0);
    // Free a page, allocate it, then walk its count up and back to free.
    send_item(ACT_SET, 10'd20, 8'd0);
    send_item(ACT_ALLOC_GEN, 10'd0, 8'd0);
    send_item(ACT_SHARE, 10'd20, 8'd0);
    send_item(ACT_FREE, 10'd20, 8'd0);
    send_item(ACT_FREE, 10'd20, 8'd0);
    send_item(ACT_FREE, 10'd20, 8'd0);
    send_item(ACT_SET, 10'd10, 8'd0);
    send_item(ACT_ALLOC_OBJ, 10'd0, 8'd0);
    // Saturation at the first page of the object region.
    send_item(ACT_SET, 10'd8, 8'd255);
    send_item(ACT_SHARE, 10'd8, 8'd0);
    send_item(ACT_FREE, 10'd8, 8'd0);
    // Set has no region check, even on a kernel page.
    send_item(ACT_SET, 10'd0, 8'd0);
    send_item(ACT_SHARE, 10'd0, 8'd0);
    send_item(ACT_SPARE_LO, 10'd1023, 8'd255);
    send_item(ACT_SPARE_HI, 10'd512, 8'd170);
    // Last page of the general region; the earlier freed page wins first.
    send_item(ACT_SET, 10'd31, 8'd0);
    send_item(ACT_ALLOC_GEN, 10'd0, 8'd0);
    send_item(ACT_ALLOC_GEN, 10'd0, 8'd0);
    send_item(ACT_ALLOC_GEN, 10'd0, 8'd0);
    drain();

    // Bounds at the top of the range: both allocators see empty regions
    // and every page is kernel memory.
    set_regions(11'd1024, 11'd1024, 11'd1024);
    send_item(ACT_ALLOC_GEN, 10'd0, 8'd0);
    send_item(ACT_ALLOC_OBJ, 10'd0, 8'd0);
    send_item(ACT_SHARE, 10'd1023, 8'd0);
    drain();

    // Bounds at zero: no kernel pages and empty regions.
    set_regions(11'd0, 11'd0, 11'd0);
    send_item(ACT_ALLOC_GEN, 10'd0, 8'd0);
    send_item(ACT_SHARE, 10'd0, 8'd0);
    send_item(ACT_FREE, 10'd0, 8'd0);
    send_item(ACT_FREE, 10'd0, 8'd0);
    drain();

    // Inverted bounds find nothing.
    set_regions(11'd40, 11'd30, 11'd20);
    send_item(ACT_ALLOC_GEN, 10'd0, 8'd0);
    send_item(ACT_ALLOC_OBJ, 10'd0, 8'd0);
    send_item(ACT_SHARE, 10'd35, 8'd0);
    drain();

    // Random phases, each with its own region layout and idling pattern.
    set_regions(11'd8, 11'd24, 11'd48);
    run_phase(145, 0, 56);
    drain();

    send_idle_pct = 51;
    set_regions(11'd0, 11'd6, 11'd1024);
    run_phase(145, 0, 48);
    drain();

    send_idle_pct = 0;
    rsp_stall_pct = 51;
    set_regions(11'd900, 11'd960, 11'd1024);
    run_phase(145, 892, 1024);
    drain();

    send_idle_pct = 29;
    rsp_stall_pct = 29;
    set_regions(11'd200, 11'd232, 11'd264);
    run_phase(145, 192, 272);
    drain();

    // Extra margin so that a stray result after the last one is still seen.
    repeat (16) @(posedge clk);
    if (mismatches == 0) begin
      $display("page_frame_refcount_allocator_top regression: pass");
    end else begin
      $display("page_frame_refcount_allocator_top regression: fail");
    end
    $finish;
  end

endmodule

/* files.f */
sv/pfra_pkg.sv
sv/pfra_ctrl.sv
sv/pfra_dp.sv
sv/page_frame_refcount_allocator_top.sv
verif/pfra_checker.sv
verif/tb.sv
